[rtl/core/icy_pkg.sv]
`timescale 1ns / 1ps
// Package with the constants and the key table of the ICY metadata demuxer.
package icy_pkg;

  localparam int unsigned INTERVAL_W = 20;
  localparam int unsigned META_CNT_W = 12;
  localparam int unsigned KEY_LEN    = 13;
  localparam int unsigned KEY_IDX_W  = 4;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_QUOTE = 8'h27;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] UTF8_MASK  = 8'hC0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  localparam logic KIND_AUDIO = 1'b0;
  localparam logic KIND_TITLE = 1'b1;

  // Characters of the title key StreamTitle=' by position.
  function automatic logic [7:0] key_char(input logic [KEY_IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h53;
      4'd1:    c = 8'h74;
      4'd2:    c = 8'h72;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h61;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h54;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h74;
      4'd9:    c = 8'h6C;
      4'd10:   c = 8'h65;
      4'd11:   c = 8'h3D;
      4'd12:   c = 8'h27;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/icy_metadata_demuxer.sv]
`timescale 1ns / 1ps
// ICY metadata demuxer: splits audio from metadata and emits new stream titles.
//
// Input channel: one stream byte per item on stream_byte_i, valid/ready.
// Output channel: output_kind_o, data_byte_o, last_of_run_o, valid/ready.
// Configuration: cfg_we_i writes cfg_wdata_i as the audio interval, which
// restarts the audio run; write it only while the block is idle.
// Audio, length and metadata bytes are accepted back to back while the output
// register is free, and an audio byte appears on it the cycle after it is accepted.
// The title key and the closing quote are matched on the fly while metadata
// arrives, and title bytes are captured into a small candidate memory.
// After the last byte of a metadata block the block is busy for a finishing
// sequence run by one sequencer over the two title memories: UTF-8 back-up at
// the cut, compare with the stored title, then copy and emission of a new title.
// A stalled receiver holds the output register; the block then takes no new
// item until the pending item leaves.
// Reset clears the interval to zero (plain passthrough) and the stored title length.
module icy_metadata_demuxer
  import icy_pkg::*;
#(
  parameter int unsigned TITLE_BYTES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [INTERVAL_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            stream_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  output_kind_o,
  output logic [7:0]            data_byte_o,
  output logic                  last_of_run_o
);

  localparam int unsigned LW = (TITLE_BYTES > 1) ? $clog2(TITLE_BYTES) : 1;
  localparam logic [LW-1:0] VLEN_MAX = LW'(TITLE_BYTES - 1);
  localparam logic [META_CNT_W-1:0] VCNT_DEPTH = META_CNT_W'(TITLE_BYTES);
  localparam logic [META_CNT_W-1:0] VCNT_MAX = META_CNT_W'(TITLE_BYTES - 1);

  typedef enum logic [1:0] {
    PH_AUDIO,
    PH_LEN,
    PH_META
  } phase_e;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_FSTART,
    ST_BK_RD,
    ST_BK_CHK,
    ST_CHKLEN,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_DONE
  } state_e;

  state_e                  state_q;
  phase_e                  phase_q;
  logic [INTERVAL_W-1:0]   interval_q;
  logic [INTERVAL_W-1:0]   audio_cd_q;
  logic [META_CNT_W-1:0]   meta_cd_q;
  logic [KEY_IDX_W-1:0]    key_idx_q;
  logic                    key_found_q;
  logic                    closed_q;
  logic                    stop_q;
  logic                    quote_q;
  logic [META_CNT_W-1:0]   vcnt_q;
  logic [LW-1:0]           vlen_q;
  logic [LW-1:0]           k_q;
  logic [LW-1:0]           prev_len_q;

  logic                    out_valid_q;
  logic                    out_kind_q;
  logic [7:0]              out_data_q;
  logic                    out_last_q;

  logic [7:0]              cand_mem [TITLE_BYTES];
  logic [7:0]              prev_mem [TITLE_BYTES];
  logic [7:0]              cand_q;
  logic [7:0]              prev_q;

  logic                    out_free;
  logic                    out_load;
  logic                    in_acc;
  logic                    is_audio;
  logic                    is_len;
  logic                    is_meta;
  logic                    cand_we;
  logic                    cand_re;
  logic                    prev_re;
  logic                    prev_we;
  logic [LW-1:0]           cand_raddr;
  logic [META_CNT_W-1:0]   meta_cd_next;
  logic [META_CNT_W-1:0]   vlen_raw;

  // Handshake and classification of the accepted byte.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_RUN) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    is_audio = 1'b0;
    is_len   = 1'b0;
    is_meta  = 1'b0;
    if (interval_q == '0) begin
      is_audio = 1'b1;
    end else begin
      case (phase_q)
        PH_AUDIO: begin
          if (audio_cd_q != '0) begin
            is_audio = 1'b1;
          end else begin
            is_len = 1'b1;
          end
        end
        PH_LEN:  is_len  = 1'b1;
        default: is_meta = 1'b1;
      endcase
    end
  end

  // The output register takes a new item in this cycle.
  assign out_load = !cfg_we_i && ((in_acc && is_audio) ||
                                  ((state_q == ST_EMIT_WR) && out_free));

  assign meta_cd_next = (meta_cd_q == '0) ? '0 : meta_cd_q - 1'b1;
  assign vlen_raw     = vcnt_q - 1'b1;

  // A value byte is captured while the title is open and fits the memory.
  assign cand_we = in_acc && is_meta && !stop_q && key_found_q && !closed_q &&
                   (stream_byte_i != CHAR_NUL) &&
                   !(quote_q && stream_byte_i == CHAR_SEMI) && (vcnt_q < VCNT_DEPTH);

  assign cand_re    = (state_q == ST_BK_RD) || (state_q == ST_CMP_RD) ||
                      (state_q == ST_EMIT_RD);
  assign cand_raddr = (state_q == ST_BK_RD) ? vlen_q : k_q;
  assign prev_re    = (state_q == ST_CMP_RD);
  assign prev_we    = (state_q == ST_EMIT_WR) && out_free;

  // Candidate title memory.
  always_ff @(posedge clk_i) begin
    if (cand_we) begin
      cand_mem[vcnt_q[LW-1:0]] <= stream_byte_i;
    end
    if (cand_re) begin
      cand_q <= cand_mem[cand_raddr];
    end
  end

  // Stored previous title memory.
  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[k_q] <= cand_q;
    end
    if (prev_re) begin
      prev_q <= prev_mem[k_q];
    end
  end

  // Sequencer, stream counters, title matcher and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      phase_q     <= PH_AUDIO;
      interval_q  <= '0;
      audio_cd_q  <= '0;
      meta_cd_q   <= '0;
      key_idx_q   <= '0;
      key_found_q <= 1'b0;
      closed_q    <= 1'b0;
      stop_q      <= 1'b0;
      quote_q     <= 1'b0;
      vcnt_q      <= '0;
      vlen_q      <= '0;
      k_q         <= '0;
      prev_len_q  <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_AUDIO;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
        audio_cd_q <= cfg_wdata_i;
        phase_q    <= PH_AUDIO;
        meta_cd_q  <= '0;
      end else begin
        case (state_q)
          ST_RUN: begin
            if (in_acc && is_audio) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= KIND_AUDIO;
              out_data_q  <= stream_byte_i;
              out_last_q  <= 1'b1;
              if (interval_q != '0) begin
                audio_cd_q <= audio_cd_q - 1'b1;
                if (audio_cd_q == INTERVAL_W'(1)) begin
                  phase_q <= PH_LEN;
                end
              end
            end else if (in_acc && is_len) begin
              meta_cd_q   <= {stream_byte_i, 4'b0000};
              key_idx_q   <= '0;
              key_found_q <= 1'b0;
              closed_q    <= 1'b0;
              stop_q      <= 1'b0;
              quote_q     <= 1'b0;
              vcnt_q      <= '0;
              if (stream_byte_i == 8'h00) begin
                audio_cd_q <= interval_q;
                phase_q    <= PH_AUDIO;
              end else begin
                phase_q <= PH_META;
              end
            end else if (in_acc && is_meta) begin
              meta_cd_q <= meta_cd_next;
              if (meta_cd_next == '0) begin
                state_q <= ST_FSTART;
              end
              if (!stop_q) begin
                if (stream_byte_i == CHAR_NUL) begin
                  stop_q <= 1'b1;
                end else if (!key_found_q) begin
                  if (stream_byte_i == key_char(key_idx_q)) begin
                    if (key_idx_q == KEY_IDX_W'(KEY_LEN - 1)) begin
                      key_found_q <= 1'b1;
                      vcnt_q      <= '0;
                      quote_q     <= 1'b0;
                    end else begin
                      key_idx_q <= key_idx_q + 1'b1;
                    end
                  end else begin
                    key_idx_q <= (stream_byte_i == CHAR_S) ? KEY_IDX_W'(1) : '0;
                  end
                end else if (!closed_q) begin
                  if (quote_q && stream_byte_i == CHAR_SEMI) begin
                    closed_q <= 1'b1;
                  end else begin
                    vcnt_q  <= vcnt_q + 1'b1;
                    quote_q <= (stream_byte_i == CHAR_QUOTE);
                  end
                end
              end
            end
          end
          // Title length with the cut at one below the title memory size.
          ST_FSTART: begin
            if (!closed_q) begin
              state_q <= ST_DONE;
            end else if (vlen_raw > VCNT_MAX) begin
              vlen_q  <= VLEN_MAX;
              state_q <= ST_BK_RD;
            end else begin
              vlen_q  <= vlen_raw[LW-1:0];
              state_q <= ST_CHKLEN;
            end
          end
          ST_BK_RD: begin
            state_q <= ST_BK_CHK;
          end
          // Back up while the byte at the cut is a UTF-8 continuation byte.
          ST_BK_CHK: begin
            if ((cand_q & UTF8_MASK) == UTF8_CONT) begin
              vlen_q  <= vlen_q - 1'b1;
              state_q <= (vlen_q == LW'(1)) ? ST_DONE : ST_BK_RD;
            end else begin
              state_q <= ST_CHKLEN;
            end
          end
          ST_CHKLEN: begin
            k_q <= '0;
            if (vlen_q == '0) begin
              state_q <= ST_DONE;
            end else if (vlen_q != prev_len_q) begin
              state_q <= ST_EMIT_RD;
            end else begin
              state_q <= ST_CMP_RD;
            end
          end
          ST_CMP_RD: begin
            state_q <= ST_CMP_CHK;
          end
          // Compare with the stored title one byte at a time.
          ST_CMP_CHK: begin
            if (cand_q != prev_q) begin
              k_q     <= '0;
              state_q <= ST_EMIT_RD;
            end else if (k_q == vlen_q - 1'b1) begin
              state_q <= ST_DONE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_CMP_RD;
            end
          end
          ST_EMIT_RD: begin
            state_q <= ST_EMIT_WR;
          end
          // Copy one title byte into the store and send it out.
          ST_EMIT_WR: begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= KIND_TITLE;
              out_data_q  <= cand_q;
              out_last_q  <= (k_q == vlen_q - 1'b1);
              if (k_q == vlen_q - 1'b1) begin
                prev_len_q <= vlen_q;
                state_q    <= ST_DONE;
              end else begin
                k_q     <= k_q + 1'b1;
                state_q <= ST_EMIT_RD;
              end
            end
          end
          // Start the next audio run.
          ST_DONE: begin
            audio_cd_q <= interval_q;
            phase_q    <= PH_AUDIO;
            state_q    <= ST_RUN;
          end
          default: begin
            state_q <= ST_RUN;
          end
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign output_kind_o = out_kind_q;
  assign data_byte_o   = out_data_q;
  assign last_of_run_o = out_last_q;

  // The emission index stays inside the title being sent.
  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_WR) |-> (k_q < vlen_q))
    else $error("title emission index beyond title length");

  // Length compare is only reached for a closed title.
  a_closed_title: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHKLEN) |-> closed_q)
    else $error("title length checked without a closing quote");

  // An accepted item leaves the block running or starts the finishing pass.
  a_accept_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_we_i) |=> (state_q == ST_RUN || state_q == ST_FSTART))
    else $error("unexpected sequencer state after an accepted item");

endmodule

[tb/tb_icy_metadata_demuxer.sv]
`timescale 1ns / 1ps
// Testbench for the ICY metadata demuxer: random streams checked against a title predictor.

// Scoreboard: predicts audio and title bytes and checks the output items.
class icy_title_scoreboard;
  logic [19:0] interval;
  logic [1:0]  phase;
  logic [19:0] audio_cnt;
  logic [11:0] meta_cnt;
  logic [11:0] meta_fill;
  logic [7:0]  meta_mem [4096];
  logic [7:0]  prev_title [64];
  int          prev_title_len;
  logic [17:0] pending_q [$];
  int          err_cnt;

  function new();
    interval = '0;
    phase = 2'd0;
    audio_cnt = '0;
    meta_cnt = '0;
    meta_fill = '0;
    prev_title_len = 0;
    err_cnt = 0;
  endfunction

  function void push_result(logic kind, logic [7:0] b, logic last);
    pending_q.push_back({7'd0, kind, b, last, 1'b0});
  endfunction

  function void set_interval(logic [19:0] v);
    interval = v;
    audio_cnt = v;
    phase = 2'd0;
    meta_cnt = '0;
    meta_fill = '0;
  endfunction

  // Finds pat within [from, lim) of the metadata memory; returns lim when absent.
  function int find_seq(int from, int lim, logic [7:0] pat [], int plen);
    int i;
    int j;
    bit hit;
    for (i = from; i + plen <= lim; i++) begin
      hit = 1;
      for (j = 0; j < plen; j++) if (meta_mem[i + j] != pat[j]) hit = 0;
      if (hit) return i;
    end
    return lim;
  endfunction

  // End of a metadata block: extract the title and queue it if it is new.
  function void close_block();
    logic [7:0] key [] = '{8'h53, 8'h74, 8'h72, 8'h65, 8'h61, 8'h6D, 8'h54,
                           8'h69, 8'h74, 8'h6C, 8'h65, 8'h3D, 8'h27};
    logic [7:0] closer [] = '{8'h27, 8'h3B};
    int lim;
    int i;
    int start;
    int stop;
    int vlen;
    bit same;
    lim = meta_fill;
    for (i = 0; i < lim; i++) if (meta_mem[i] == 8'h00) begin
      lim = i;
      break;
    end
    start = find_seq(0, lim, key, 13);
    if (start >= lim) return;
    start += 13;
    stop = find_seq(start, lim, closer, 2);
    if (stop >= lim) return;
    vlen = stop - start;
    if (vlen > 63) begin
      vlen = 63;
      while (vlen > 0 && (meta_mem[start + vlen] & 8'hC0) == 8'h80) vlen--;
    end
    if (vlen == 0) return;
    same = (vlen == prev_title_len);
    if (same) for (i = 0; i < vlen; i++) if (prev_title[i] != meta_mem[start + i]) same = 0;
    if (same) return;
    for (i = 0; i < vlen; i++) begin
      prev_title[i] = meta_mem[start + i];
      push_result(1'b1, prev_title[i], i + 1 == vlen);
    end
    prev_title_len = vlen;
  endfunction

  // Notes one accepted stream byte.
  function void note_input(logic [7:0] b);
    if (interval == 0) begin
      push_result(1'b0, b, 1'b1);
      return;
    end
    if (phase == 2'd0 && audio_cnt != 0) begin
      push_result(1'b0, b, 1'b1);
      audio_cnt--;
      if (audio_cnt == 0) phase = 2'd1;
      return;
    end
    if (phase == 2'd0 || phase == 2'd1) begin
      meta_cnt = {b, 4'd0};
      meta_fill = '0;
      if (meta_cnt == 0) begin
        audio_cnt = interval;
        phase = 2'd0;
      end else begin
        phase = 2'd2;
      end
      return;
    end
    meta_mem[meta_fill] = b;
    meta_fill++;
    if (meta_cnt != 0) meta_cnt--;
    if (meta_cnt == 0) begin
      close_block();
      audio_cnt = interval;
      phase = 2'd0;
    end
  endfunction

  // Checks one output item against the oldest expectation.
  function void check_output(logic kind, logic [7:0] b, logic last);
    logic [17:0] e;
    if (pending_q.size() == 0) begin
      $error("unexpected output item kind=%0d byte=%h", kind, b);
      err_cnt++;
      return;
    end
    e = pending_q.pop_front();
    if (e[10] !== kind) begin
      $error("output_kind expected %0d actual %0d", e[10], kind);
      err_cnt++;
    end
    if (e[9:2] !== b) begin
      $error("data_byte expected %h actual %h", e[9:2], b);
      err_cnt++;
    end
    if (e[1] !== last) begin
      $error("last_of_run expected %0d actual %0d", e[1], last);
      err_cnt++;
    end
  endfunction
endclass

module tb_icy_metadata_demuxer;
  import icy_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [INTERVAL_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] stream_byte_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic output_kind_o;
  logic [7:0] data_byte_o;
  logic last_of_run_o;

  icy_title_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;
  int title_no = 0;

  localparam int QUIET_LIMIT = 20000;

  icy_metadata_demuxer u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .stream_byte_i, .out_valid_o, .out_ready_i, .output_kind_o,
    .data_byte_o, .last_of_run_o
  );

  always #5 clk_i = ~clk_i;

  // Output side: random stall, scoreboard check on each accepted item; accepted input bytes are noted too.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_output(output_kind_o, data_byte_o, last_of_run_o);
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(stream_byte_i);
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Sends one stream byte, with an optional random idle gap first.
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  task automatic write_interval(logic [19:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_interval(v);
  endtask

  task automatic send_audio(int n);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  // Sends a length byte and a metadata block of len*16 bytes built from text.
  task automatic send_meta(logic [7:0] len, string text);
    int i;
    send_byte(len);
    for (i = 0; i < len * 16; i++)
      send_byte(i < text.len() ? text.getc(i) : 8'h00);
  endtask

  // Builds random title text: ASCII, UTF-8 multi-byte, sometimes long or broken.
  function automatic string make_meta_text();
    string s;
    string t;
    int n;
    int i;
    int mode;
    logic [7:0] c;
    mode = $urandom_range(9);
    t = "";
    n = (mode == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) begin
        t = {t, string'(8'hE2)};
        c = 8'(8'h80 | $urandom_range(63));
        t = {t, string'(c)};
        c = 8'(8'h80 | $urandom_range(63));
        t = {t, string'(c)};
      end else begin
        c = 8'(8'h20 + $urandom_range(94));
        if (c == CHAR_QUOTE) c = 8'h41;
        t = {t, string'(c)};
      end
    end
    if ($urandom_range(3) == 0) begin
      t = $sformatf("T%0d", title_no % 3);
      title_no++;
    end
    case (mode)
      1: s = {"StreamTitle='", t};
      2: s = {"StreamTitl='", t, "';"};
      3: s = {"x", string'(8'hFF), "StreamTitle='", t, "';StreamUrl='';"};
      default: s = {"StreamTitle='", t, "';"};
    endcase
    return s;
  endfunction

  // One random stream segment at the current interval.
  task automatic random_segment(int unsigned iv, int blocks);
    string s;
    int len;
    repeat (blocks) begin
      send_audio(iv);
      if ($urandom_range(9) == 0) begin
        send_byte(8'h00);
      end else begin
        s = make_meta_text();
        len = (s.len() + 15) / 16;
        if (len == 0 || $urandom_range(5) == 0) len = $urandom_range(1, 4);
        send_meta(8'(len), s);
      end
    end
  endtask

  initial begin
    int p;
    int pcts [4] = '{0, 67, 0, 37};
    int rpcts [4] = '{0, 0, 67, 37};
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: passthrough of extreme bytes, then titles and special cases.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    go_idle();
    write_interval(20'd1);
    send_audio(1);
    send_meta(1, "StreamTitle='A';");
    send_audio(1);
    send_meta(1, "StreamTitle='A';");
    send_audio(1);
    send_byte(8'h00);
    send_audio(1);
    send_meta(1, "StreamTitle='';");
    send_audio(1);
    send_meta(2, {"StreamTitle='B", string'(8'h00), "';"});
    send_audio(1);
    send_meta(5, {"StreamTitle='", {62{"x"}}, string'(8'hE2), string'(8'h82),
                  string'(8'hAC), "';"});
    send_audio(1);
    send_meta(5, {"StreamTitle='", {64{"y"}}, "';"});
    go_idle();
    write_interval(20'hFFFFF);
    send_audio(3);
    go_idle();
    write_interval(20'd0);
    send_audio(3);
    go_idle();

    // Long hold-off on the receiver while the sender keeps offering items.
    write_interval(20'd2);
    hold_off = 1;
    fork
      random_segment(2, 1);
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
    join
    go_idle();

    // Random phases with different idle patterns and intervals.
    for (p = 0; p < 4; p++) begin
      send_idle_pct = pcts[p];
      recv_stall_pct = rpcts[p];
      write_interval(20'($urandom_range(1, 6)));
      random_segment(sb.interval, 1);
      go_idle();
    end

    if (sb.err_cnt == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
